>>> design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros, clocked on a rising edge with an
// active-low asynchronous reset as disable
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every edge out of reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// antecedent implies consequent in the same cycle
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> design/phcb_pkg.sv
// ----------------------------------------------------------------------------
// phcb_pkg
// types and operation codes for the page history cursor buffer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package phcb_pkg;

	localparam logic [2:0] OP_START = 3'd0;
	localparam logic [2:0] OP_PREV  = 3'd1;
	localparam logic [2:0] OP_NEXT  = 3'd2;
	localparam logic [2:0] OP_ADD   = 3'd3;
	localparam logic [2:0] OP_QUERY = 3'd4;

	typedef struct packed {
		logic [2:0]  op;
		logic [31:0] offset;
	} item_t;

	typedef struct packed {
		logic [31:0] page_offset;
		logic [4:0]  page_number;
		logic        can_go_back;
		logic        can_go_forward;
	} result_t;

	// cursor status after one operation, travels next to the memory read
	typedef struct packed {
		logic       has_page;
		logic [4:0] page_number;
		logic       can_go_back;
		logic       can_go_forward;
	} page_status_t;

endpackage

>>> design/phcb_ram.sv
// ----------------------------------------------------------------------------
// phcb_ram
// generic single-write, single-read synchronous ram with registered read
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module phcb_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

>>> design/phcb_ctrl.sv
// ----------------------------------------------------------------------------
// phcb_ctrl
// cursor, fill count and ring base; turns one operation into a store
// write on start or add, a store read at the new cursor and the cursor status
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module phcb_ctrl
	import phcb_pkg::*;
#(
	parameter int HISTORY_DEPTH = 16,
	localparam int AW = $clog2(HISTORY_DEPTH),
	localparam int CW = $clog2(HISTORY_DEPTH + 1)
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         accept,
	input  item_t        item,
	output logic         wr_en,
	output logic [AW-1:0] wr_addr,
	output logic [31:0]  wr_data,
	output logic         rd_en,
	output logic [AW-1:0] rd_addr,
	output page_status_t status
);

	localparam logic [CW-1:0] DEPTH_C = CW'(HISTORY_DEPTH);
	localparam logic [AW:0]   DEPTH_W = (AW + 1)'(HISTORY_DEPTH);

	logic [CW-1:0] cursor_q, cursor_n;
	logic [CW-1:0] filled_q, filled_n;
	logic [AW-1:0] base_q, base_n;
	logic [AW-1:0] wr_log;
	logic          shift;
	logic [CW-1:0] cursor_m1;

	// logical slot to physical ram address in the ring
	function automatic logic [AW-1:0] phys(input logic [AW-1:0] base, input logic [AW-1:0] idx);
		logic [AW:0] sum;
		sum = {1'b0, base} + {1'b0, idx};
		if (sum >= DEPTH_W) begin
			sum = sum - DEPTH_W;
		end
		return sum[AW-1:0];
	endfunction

	always_comb begin
		cursor_n = cursor_q;
		filled_n = filled_q;
		base_n   = base_q;
		wr_en    = 1'b0;
		wr_log   = '0;
		shift    = 1'b0;
		unique case (item.op)
			OP_START: begin
				cursor_n = CW'(1);
				filled_n = CW'(1);
				wr_en    = accept;
			end
			OP_PREV: begin
				if (cursor_q > CW'(1)) begin
					cursor_n = cursor_q - CW'(1);
				end
			end
			OP_NEXT: begin
				if (cursor_q < filled_q) begin
					cursor_n = cursor_q + CW'(1);
				end
			end
			OP_ADD: begin
				wr_en = accept;
				if (cursor_q < DEPTH_C) begin
					wr_log = cursor_q[AW-1:0];
					if (cursor_q + CW'(1) > filled_q) begin
						filled_n = cursor_q + CW'(1);
					end
				end else begin
					// full: oldest slot becomes the newest, base moves up one
					shift    = 1'b1;
					base_n   = phys(base_q, AW'(1));
					cursor_n = DEPTH_C;
				end
			end
			default: begin
			end
		endcase
	end

	assign cursor_m1 = cursor_n - CW'(1);
	assign wr_addr   = shift ? base_q : phys(base_q, wr_log);
	assign wr_data   = item.offset;
	assign rd_en     = accept;
	assign rd_addr   = phys(base_n, cursor_m1[AW-1:0]);

	assign status.has_page       = (cursor_n != '0);
	assign status.page_number    = 5'(cursor_n);
	assign status.can_go_back    = (cursor_n > CW'(1));
	assign status.can_go_forward = (cursor_n < filled_n);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_q <= '0;
			filled_q <= '0;
			base_q   <= '0;
		end else if (accept) begin
			cursor_q <= cursor_n;
			filled_q <= filled_n;
			base_q   <= base_n;
		end
	end

	`ASSERT_ALWAYS(a_cursor_in_fill, clk, arst_n, cursor_q <= filled_q, "cursor beyond fill count")
	`ASSERT_ALWAYS(a_fill_in_range, clk, arst_n, filled_q <= DEPTH_C, "fill count beyond depth")
	`ASSERT_IMPL(a_shift_when_full, clk, arst_n, accept && shift, filled_q == DEPTH_C,
		"ring shift without a full store")

endmodule

>>> design/page_history_cursor_buffer.sv
// ----------------------------------------------------------------------------
// page_history_cursor_buffer
// back/forward history of page start offsets with a cursor, offsets held
// in a ring-addressed ram
// ----------------------------------------------------------------------------
//  channel  direction  payload   handshake
//  item     in         item_t    item_valid / item_stall
//  result   out        result_t  result_valid / result_stall
//
//  one item per cycle sustained while the result is not stalled; the result
//  passes through the ram read stage, then the output register
//  the offset read at the new cursor is forwarded when the same item wrote it
//  reset clears cursor, fill count and ring base; the ram needs no clearing
//  a stalled result holds one item in the read stage, then item_stall rises
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module page_history_cursor_buffer
	import phcb_pkg::*;
#(
	parameter int HISTORY_DEPTH = 16
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    item_valid,
	output logic    item_stall,
	input  item_t   item,
	output logic    result_valid,
	input  logic    result_stall,
	output result_t result
);

	localparam int AW = $clog2(HISTORY_DEPTH);

	logic          accept;
	logic          advance;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic [31:0]   wr_data;
	logic          rd_en;
	logic [AW-1:0] rd_addr;
	logic [31:0]   rd_data;
	page_status_t  status;

	logic          s1_valid_q;
	page_status_t  status_s1;
	logic          fwd_hit_s1;
	logic [31:0]   fwd_data_s1;
	logic          result_valid_q;
	result_t       result_q;
	logic [31:0]   offset_s1;

	assign accept     = item_valid && !item_stall;
	assign advance    = s1_valid_q && (!result_valid_q || !result_stall);
	assign item_stall = s1_valid_q && !advance;

	phcb_ctrl #(
		.HISTORY_DEPTH(HISTORY_DEPTH)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.item    (item),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.status  (status)
	);

	phcb_ram #(
		.WIDTH(32),
		.DEPTH(HISTORY_DEPTH)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// read stage payload, no reset needed
	always_ff @(posedge clk) begin
		if (accept) begin
			status_s1   <= status;
			fwd_hit_s1  <= wr_en && (wr_addr == rd_addr);
			fwd_data_s1 <= wr_data;
		end
	end

	always_comb begin
		if (!status_s1.has_page) begin
			offset_s1 = '0;
		end else if (fwd_hit_s1) begin
			offset_s1 = fwd_data_s1;
		end else begin
			offset_s1 = rd_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q     <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				s1_valid_q <= 1'b1;
			end else if (advance) begin
				s1_valid_q <= 1'b0;
			end
			if (advance) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q.page_offset    <= offset_s1;
			result_q.page_number    <= status_s1.page_number;
			result_q.can_go_back    <= status_s1.can_go_back;
			result_q.can_go_forward <= status_s1.can_go_forward;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	`ASSERT_IMPL(a_stall_cause, clk, arst_n, item_stall, result_valid_q && result_stall,
		"input stalled without a stalled result")
	`ASSERT_NEXT(a_s1_held, clk, arst_n, s1_valid_q && item_stall, s1_valid_q,
		"read stage lost an item while stalled")
	`ASSERT_NEXT(a_s1_to_out, clk, arst_n, advance, result_valid_q,
		"read stage moved without filling the output")

endmodule

>>> sim/page_history_cursor_buffer_tb.sv
// ----------------------------------------------------------------------------
// page_history_cursor_buffer_tb
// drives page history operations through the item channel and checks each
// result against a cycle-free model of the history store and cursor, under
// random and long stalls on both channels
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module page_history_cursor_buffer_tb;
	import phcb_pkg::*;

	localparam int HISTORY_DEPTH  = 16;
	localparam int RANDOM_ITEMS   = 528;
	localparam int LONG_HOLD      = 240;
	localparam int DRAIN_CYCLES   = 12;
	localparam int WATCHDOG_LIMIT = 5000;

	// codes outside the defined set, the block treats them as query
	localparam logic [2:0] OP_SPARE_LO = 3'd5;
	localparam logic [2:0] OP_SPARE_HI = 3'd7;

	// history store and cursor as the block should hold them
	class page_history_scoreboard;
		logic [31:0] offsets [HISTORY_DEPTH];
		int unsigned filled;
		int unsigned cursor;	// position plus one, 0 means no page
		result_t     pending[$];
		int          mismatches;

		function new();
			foreach (offsets[i])
				offsets[i] = '0;
			filled     = 0;
			cursor     = 0;
			mismatches = 0;
		endfunction

		function void note_item(item_t it);
			result_t exp;
			case (it.op)
				OP_START: begin
					offsets[0] = it.offset;
					filled     = 1;
					cursor     = 1;
				end
				OP_PREV: begin
					if (cursor > 1)
						cursor--;
				end
				OP_NEXT: begin
					if (cursor < filled)
						cursor++;
				end
				OP_ADD: begin
					if (cursor < HISTORY_DEPTH) begin
						offsets[cursor] = it.offset;
						if (cursor + 1 > filled)
							filled = cursor + 1;
					end else begin
						// full: drop the oldest page
						for (int i = 0; i < HISTORY_DEPTH - 1; i++)
							offsets[i] = offsets[i + 1];
						offsets[HISTORY_DEPTH - 1] = it.offset;
						cursor = HISTORY_DEPTH;
					end
				end
				default: ;
			endcase
			exp.page_offset    = (cursor >= 1) ? offsets[cursor - 1] : 32'd0;
			exp.page_number    = 5'(cursor);
			exp.can_go_back    = (cursor > 1);
			exp.can_go_forward = (cursor < filled);
			pending.push_back(exp);
		endfunction

		function void check_result(result_t got);
			result_t exp;
			if (pending.size() == 0) begin
				$display("%0t: result with nothing pending: %p", $time, got);
				mismatches++;
				return;
			end
			exp = pending.pop_front();
			if (got.page_offset !== exp.page_offset) begin
				$display("%0t: page_offset expected %h actual %h",
					$time, exp.page_offset, got.page_offset);
				mismatches++;
			end
			if (got.page_number !== exp.page_number) begin
				$display("%0t: page_number expected %0d actual %0d",
					$time, exp.page_number, got.page_number);
				mismatches++;
			end
			if (got.can_go_back !== exp.can_go_back) begin
				$display("%0t: can_go_back expected %b actual %b",
					$time, exp.can_go_back, got.can_go_back);
				mismatches++;
			end
			if (got.can_go_forward !== exp.can_go_forward) begin
				$display("%0t: can_go_forward expected %b actual %b",
					$time, exp.can_go_forward, got.can_go_forward);
				mismatches++;
			end
		endfunction

		function int outstanding();
			return pending.size();
		endfunction
	endclass

	logic    clk          = 1'b0;
	logic    arst_n       = 1'b0;
	logic    item_valid   = 1'b0;
	logic    item_stall;
	item_t   item         = '0;
	logic    result_valid;
	logic    result_stall = 1'b0;
	result_t result;

	page_history_scoreboard history_sb = new();

	int unsigned send_idle_pct = 0;
	int unsigned recv_idle_pct = 0;
	bit          hold_req      = 1'b0;
	int          items_sent    = 0;

	page_history_cursor_buffer #(
		.HISTORY_DEPTH(HISTORY_DEPTH)
	) i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_stall  (item_stall),
		.item        (item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result      (result)
	);

	always #5 clk = ~clk;

	// receiver stall, with a long hold-off on request
	initial begin : result_stall_drive
		int unsigned hold_left;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (hold_left != 0) begin
				result_stall <= 1'b1;
				hold_left--;
			end else if (hold_req) begin
				hold_req = 1'b0;
				hold_left = LONG_HOLD - 1;
				result_stall <= 1'b1;
			end else begin
				result_stall <= ($urandom_range(99) < recv_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (result_valid === 1'b1 && result_stall === 1'b0)
			history_sb.check_result(result);
	end

	initial begin : watchdog
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((item_valid && item_stall === 1'b0) ||
			    (result_valid === 1'b1 && !result_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// called at a rising edge, returns at the edge of the transfer
	task automatic send_op(input logic [2:0] op, input logic [31:0] offset);
		item_t it;
		it.op     = op;
		it.offset = offset;
		while ($urandom_range(99) < send_idle_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		item       <= it;
		do
			@(posedge clk);
		while (item_stall !== 1'b0);
		history_sb.note_item(it);
		items_sent++;
	endtask

	task automatic send_random_op();
		logic [2:0]  op;
		logic [31:0] offset;
		int unsigned pick;
		pick = $urandom_range(99);
		if (pick < 40)
			op = OP_ADD;
		else if (pick < 76)
			op = OP_NEXT;
		else if (pick < 88)
			op = OP_PREV;
		else if (pick < 93)
			op = OP_QUERY;
		else if (pick < 97)
			op = 3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
		else
			op = OP_START;
		case ($urandom_range(7))
			0:       offset = '0;
			1:       offset = '1;
			default: offset = $urandom;
		endcase
		send_op(op, offset);
	endtask

	task automatic wait_drained();
		item_valid <= 1'b0;
		@(posedge clk);
		while (history_sb.outstanding() != 0)
			@(posedge clk);
	endtask

	initial begin : stimulus
		int target;
		int seq_len;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 6;
		recv_idle_pct = 67;

		// before any start: no cursor, then add next seeds slot 0
		send_op(OP_QUERY, 32'h0);
		send_op(OP_PREV,  32'h0);
		send_op(OP_NEXT,  32'h0);
		send_op(OP_ADD,   32'hFFFF_FFFF);
		send_op(OP_QUERY, 32'h0);
		send_op(OP_NEXT,  32'h0);
		send_op(OP_START, 32'h0);
		send_op(OP_START, 32'hFFFF_FFFF);
		send_op(OP_ADD,   32'h1234_5678);
		send_op(OP_NEXT,  32'h0);
		send_op(OP_NEXT,  32'h0);
		send_op(OP_PREV,  32'h0);
		send_op(OP_PREV,  32'h0);
		send_op(OP_ADD,   32'hA5A5_A5A5);
		for (int op = OP_SPARE_LO; op <= OP_SPARE_HI; op++)
			send_op(3'(op), $urandom);
		// restart leaves old slots behind but out of reach
		send_op(OP_START, 32'h0000_0001);
		send_op(OP_NEXT,  32'h0);
		send_op(OP_ADD,   32'h8000_0000);
		send_op(OP_NEXT,  32'h0);
		send_op(OP_QUERY, 32'h0);

		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					send_idle_pct = 6;
					recv_idle_pct = 67;
				end
				1: begin
					send_idle_pct = 67;
					recv_idle_pct = 6;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			target = items_sent + RANDOM_ITEMS / 3;
			while (items_sent < target) begin
				// each sequence opens a fresh history and mostly grows it
				send_op(OP_START, $urandom);
				seq_len = $urandom_range(8, 60);
				for (int i = 0; i < seq_len && items_sent < target; i++) begin
					if (phase == 0 && i == 20 && !hold_req)
						hold_req = 1'b1;
					if (phase == 1 && i == 20)
						wait_drained();
					send_random_op();
				end
			end
		end

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (history_sb.mismatches == 0 && history_sb.outstanding() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
